/* rtl/plc_pkg.sv */
package plc_pkg;

    // Letter and key geometry.
    localparam int LETTER_W            = 5;
    localparam int KEY_LEN_W           = 4;
    localparam int KEY_SLOTS           = 12;
    localparam int KEY_LETTERS_W       = KEY_SLOTS * LETTER_W;
    localparam int MAX_KEY_LETTERS_DEF = 12;
    localparam int CFG_INDEX_W         = 2;

    localparam logic [LETTER_W-1:0] ALPHABET = LETTER_W'(26);

    typedef logic [LETTER_W-1:0] letter_t;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_CIPHER_MODE = 2'd0,
        REG_DECIPHER    = 2'd1,
        REG_KEY_LENGTH  = 2'd2,
        REG_KEY_LETTERS = 2'd3
    } cfg_reg_t;

    // Input beat.
    typedef struct packed {
        letter_t letter_in;
        logic    end_of_message;
    } in_beat_t;

    // Output beat.
    typedef struct packed {
        letter_t letter_out;
        logic    last_out;
    } out_beat_t;

    // Configuration registers as seen by the datapath.
    typedef struct packed {
        logic                     cipher_mode;
        logic                     decipher;
        logic [KEY_LEN_W-1:0]     key_length;
        logic [KEY_LETTERS_W-1:0] key_letters;
    } cfg_t;

    // Fold a 5-bit code into 0..25; one subtract is enough below 32.
    function automatic letter_t mod26(input letter_t v);
        mod26 = (v >= ALPHABET) ? v - ALPHABET : v;
    endfunction

    // Shift a letter by a key letter modulo 26; both operands are below 26.
    function automatic letter_t shift_mod26(input letter_t letter, input letter_t k,
                                            input logic sub);
        logic [LETTER_W:0] sum;
        if (sub)
        begin
            sum = {1'b0, letter} + {1'b0, ALPHABET} - {1'b0, k};
        end
        else
        begin
            sum = {1'b0, letter} + {1'b0, k};
        end
        if (sum >= {1'b0, ALPHABET})
        begin
            sum = sum - {1'b0, ALPHABET};
        end
        shift_mod26 = sum[LETTER_W-1:0];
    endfunction

endpackage

/* rtl/plc_cfg_regs.sv */
module plc_cfg_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    input  logic [plc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [plc_pkg::KEY_LETTERS_W-1:0]   cfg_data,
    output plc_pkg::cfg_t                       cfg
);
    import plc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Register decode; the port is always ready, so valid alone writes.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_CIPHER_MODE: cfg_next.cipher_mode = cfg_data[0];
                REG_DECIPHER:    cfg_next.decipher    = cfg_data[0];
                REG_KEY_LENGTH:  cfg_next.key_length  = cfg_data[KEY_LEN_W-1:0];
                REG_KEY_LETTERS: cfg_next.key_letters = cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cipher_mode <= 1'b0;
            cfg_reg.decipher    <= 1'b0;
            cfg_reg.key_length  <= KEY_LEN_W'(1);
            cfg_reg.key_letters <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/plc_core.sv */
module plc_core #(
    parameter int MAX_KEY_LETTERS = plc_pkg::MAX_KEY_LETTERS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  plc_pkg::cfg_t       cfg,
    input  logic                fire,
    input  plc_pkg::in_beat_t   beat_in,
    output plc_pkg::out_beat_t  beat_out
);
    import plc_pkg::*;

    localparam int POS_W = (MAX_KEY_LETTERS > 1) ? $clog2(MAX_KEY_LETTERS) : 1;

    logic [POS_W-1:0]     pos_reg;
    logic [POS_W-1:0]     pos_next;
    logic                 first_reg;
    logic                 first_next;
    letter_t              ring_reg [MAX_KEY_LETTERS];

    logic [KEY_LEN_W-1:0] len;
    logic                 wrap;
    logic [POS_W-1:0]     pos_cur;
    logic                 first_cur;
    logic [KEY_LEN_W-1:0] pos_inc;
    logic [5:0]           key_base;
    letter_t              key_letter;
    letter_t              k;
    letter_t              letter;
    letter_t              result;
    letter_t              plain;

    // Active key length, clamped to 1..MAX_KEY_LETTERS.
    always_comb
    begin
        if (cfg.key_length == '0)
        begin
            len = KEY_LEN_W'(1);
        end
        else if (cfg.key_length > KEY_LEN_W'(MAX_KEY_LETTERS))
        begin
            len = KEY_LEN_W'(MAX_KEY_LETTERS);
        end
        else
        begin
            len = cfg.key_length;
        end
    end

    // A position left beyond a shortened key wraps to the start.
    assign wrap      = KEY_LEN_W'(pos_reg) >= len;
    assign pos_cur   = wrap ? '0 : pos_reg;
    assign first_cur = wrap ? 1'b0 : first_reg;

    // Key letter selection: the key itself, or plaintext from the ring in autokey.
    assign key_base   = 6'(pos_cur) * 6'(LETTER_W);
    assign key_letter = mod26(cfg.key_letters[key_base +: LETTER_W]);
    assign k          = (cfg.cipher_mode && !first_cur) ? ring_reg[pos_cur] : key_letter;

    // Letter shift and the plaintext that feeds the autokey stream.
    assign letter = mod26(beat_in.letter_in);
    assign result = shift_mod26(letter, k, cfg.decipher);
    assign plain  = cfg.decipher ? result : letter;

    assign beat_out.letter_out = result;
    assign beat_out.last_out   = beat_in.end_of_message;

    // Position advance, end-of-key wrap and end-of-message restart.
    always_comb
    begin
        pos_inc    = KEY_LEN_W'(pos_cur) + KEY_LEN_W'(1);
        pos_next   = pos_reg;
        first_next = first_reg;
        if (fire)
        begin
            if (beat_in.end_of_message)
            begin
                pos_next   = '0;
                first_next = 1'b1;
            end
            else if (pos_inc >= len)
            begin
                pos_next   = '0;
                first_next = 1'b0;
            end
            else
            begin
                pos_next   = pos_inc[POS_W-1:0];
                first_next = first_cur;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            first_reg <= 1'b1;
        end
        else
        begin
            pos_reg   <= pos_next;
            first_reg <= first_next;
        end
    end

    // Plaintext ring, written at the position just used.
    always_ff @(posedge clk)
    begin
        if (fire && cfg.cipher_mode)
        begin
            ring_reg[pos_cur] <= plain;
        end
    end

endmodule

/* rtl/polyalphabetic_letter_cipher_top.sv */
// Vigenere and autokey letter cipher. Each input beat carries one letter
// (0 = A .. 25 = Z) and an end-of-message flag, and yields exactly one output
// beat with the shifted letter and the copied flag, in order. The block takes
// one letter per cycle while the output is not stalled: a letter is captured in
// an input register, then shifted and written to the result register when it
// frees up. The rate is set by the per-letter update of the key position and
// the plaintext ring. While a result waits on a stalled output, the input
// register can still take one more letter; after that the input stalls until
// the result is taken. The configuration port is always ready;
// write it only while no letter is in flight. A letter flagged end of message
// restarts the key stream for the next message.
module polyalphabetic_letter_cipher_top #(
    parameter int MAX_KEY_LETTERS = plc_pkg::MAX_KEY_LETTERS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  plc_pkg::in_beat_t                   in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output plc_pkg::out_beat_t                  out_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [plc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [plc_pkg::KEY_LETTERS_W-1:0]   cfg_data
);
    import plc_pkg::*;

    cfg_t      cfg;
    logic      in_hold_reg;
    in_beat_t  in_data_reg;
    logic      out_valid_reg;
    out_beat_t out_data_reg;
    out_beat_t result;
    logic      take_in;
    logic      move;

    assign cfg_ready = 1'b1;

    plc_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    plc_core #(
        .MAX_KEY_LETTERS (MAX_KEY_LETTERS)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .fire     (move),
        .beat_in  (in_data_reg),
        .beat_out (result)
    );

    // Handshake: the held letter moves on whenever the result register frees up.
    assign move     = in_hold_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_hold_reg && !move;
    assign take_in  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_hold_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take_in)
            begin
                in_hold_reg <= 1'b1;
            end
            else if (move)
            begin
                in_hold_reg <= 1'b0;
            end
            if (move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            in_data_reg <= in_data;
        end
        if (move)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // The input side only stalls behind a full, stalled result register.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid_reg && out_stall))
        else $error("input stalled without a blocked result");

    // Every result letter is a valid letter.
    a_letter_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.letter_out < ALPHABET))
        else $error("result letter out of range");

    // A moved letter shows up as a result carrying its own end-of-message flag.
    a_flag_follows: assert property (@(posedge clk) disable iff (!rst_n)
        move |=> (out_valid && out_data.last_out == $past(in_data_reg.end_of_message)))
        else $error("result flag does not follow its letter");

endmodule
